/* rtl/ttce_pkg.sv */
package ttce_pkg;

	localparam int CHAR_W  = 8;
	localparam int POS_W   = 8;
	localparam int COLOR_W = 24;
	localparam int ACT_W   = 2;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 3 * POS_W + 2 * COLOR_W;

	localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SCROLL = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

	localparam logic CMD_PUT   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [POS_W:0] TAB_STEP = 9'd4;

	localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd0;
	localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd1;
	localparam logic [IDX_W-1:0] REG_FG_COLOR = 2'd2;
	localparam logic [IDX_W-1:0] REG_BG_COLOR = 2'd3;

	localparam logic [POS_W-1:0]   RST_NUM_COLS = 8'd80;
	localparam logic [POS_W-1:0]   RST_NUM_ROWS = 8'd25;
	localparam logic [COLOR_W-1:0] RST_FG_COLOR = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] RST_BG_COLOR = 24'h000000;

endpackage

/* rtl/text_terminal_cursor_engine.sv */
// a transferred command is held in ST_CMD, which registers its result; a tab or newline goes on to ST_TAB or ST_LINE
// a tab that draws nothing and only scrolls passes from ST_TAB to ST_LINE, which registers the scroll result
// a tab stays in ST_TAB and draws one blank cell per step until it reaches its stop
// a line advance after a wrap, a tab or a newline goes through ST_LINE, and a stalled result holds the sequencer
// one command at a time: s_tready is high only while the sequencer is idle
// reset: cursor homed, registers 80 columns, 25 rows, white on black, no result
module text_terminal_cursor_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ttce_pkg::CHAR_W-1:0]   s_tdata,   // char_code
	input  logic                          s_tuser,   // command
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ttce_pkg::DATA_W-1:0]   m_tdata,   // column, row, glyph, draw_fg, draw_bg
	output logic [ttce_pkg::ACT_W-1:0]    m_tuser,   // action
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [ttce_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ttce_pkg::COLOR_W-1:0]  cfg_wdata
);
	import ttce_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_TAB,
		ST_LINE
	} state_t;

	state_t               state_q;
	logic [POS_W-1:0]     num_cols_q;
	logic [POS_W-1:0]     num_rows_q;
	logic [COLOR_W-1:0]   fg_color_q;
	logic [COLOR_W-1:0]   bg_color_q;
	logic [POS_W-1:0]     cursor_col_q;
	logic [POS_W-1:0]     cursor_row_q;
	logic                 cmd_q;
	logic [CHAR_W-1:0]    char_q;
	logic [POS_W:0]       tab_stop_q;
	logic                 out_valid_q;
	logic [ACT_W-1:0]     out_act_q;
	logic [DATA_W-1:0]    out_data_q;
	logic                 out_last_q;

	logic           slot_free;
	logic [POS_W:0] col_ext;
	logic [POS_W:0] col_inc;
	logic [POS_W:0] row_inc;
	logic [POS_W:0] cols_ext;
	logic           line_scrolls;
	logic           col_wraps;
	logic           tab_here;
	logic           tab_more;
	logic           out_load;

	always_comb begin
		slot_free    = !out_valid_q || m_tready;
		col_ext      = {1'b0, cursor_col_q};
		col_inc      = col_ext + 9'd1;
		row_inc      = {1'b0, cursor_row_q} + 9'd1;
		cols_ext     = {1'b0, num_cols_q};
		line_scrolls = row_inc >= {1'b0, num_rows_q};
		col_wraps    = col_inc >= cols_ext;
		tab_here     = (col_ext < tab_stop_q) && (col_ext < cols_ext);
		tab_more     = (col_inc < tab_stop_q) && (col_inc < cols_ext);
		// a new result enters the output register this cycle
		case (state_q)
			ST_CMD:  out_load = slot_free && ((cmd_q == CMD_CLEAR) ||
				(char_q == CH_BS && cursor_col_q != '0) ||
				!(char_q inside {CH_LF, CH_CR, CH_BS, CH_TAB}));
			ST_TAB:  out_load = slot_free && tab_here;
			ST_LINE: out_load = slot_free && line_scrolls;
			default: out_load = 1'b0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_act_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= RST_NUM_COLS;
			num_rows_q <= RST_NUM_ROWS;
			fg_color_q <= RST_FG_COLOR;
			bg_color_q <= RST_BG_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_COLS: num_cols_q <= cfg_wdata[POS_W-1:0];
				REG_NUM_ROWS: num_rows_q <= cfg_wdata[POS_W-1:0];
				REG_FG_COLOR: fg_color_q <= cfg_wdata;
				REG_BG_COLOR: bg_color_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= CMD_PUT;
			char_q       <= '0;
			tab_stop_q   <= '0;
			out_act_q    <= ACT_DRAW;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						char_q  <= s_tdata;
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					if (slot_free) begin
						if (cmd_q == CMD_CLEAR) begin
							out_act_q    <= ACT_CLEAR;
							out_data_q   <= '0;
							out_last_q   <= 1'b1;
							cursor_col_q <= '0;
							cursor_row_q <= '0;
							state_q      <= ST_IDLE;
						end else begin
							case (char_q)
								CH_LF: state_q <= ST_LINE;
								CH_CR: begin
									cursor_col_q <= '0;
									state_q      <= ST_IDLE;
								end
								CH_BS: begin
									if (cursor_col_q != '0) begin
										cursor_col_q <= cursor_col_q - 8'd1;
										out_act_q    <= ACT_DRAW;
										out_data_q   <= {bg_color_q, fg_color_q, CH_SPACE,
											cursor_row_q, cursor_col_q - 8'd1};
										out_last_q   <= 1'b1;
									end
									state_q <= ST_IDLE;
								end
								CH_TAB: begin
									// next multiple of four above the cursor
									tab_stop_q <= {1'b0, cursor_col_q[POS_W-1:2], 2'b00} + TAB_STEP;
									state_q    <= ST_TAB;
								end
								default: begin
									out_act_q   <= ACT_DRAW;
									out_data_q  <= {bg_color_q, fg_color_q, char_q,
										cursor_row_q, cursor_col_q};
									// not last if a wrap will also scroll
									out_last_q  <= !(col_wraps && line_scrolls);
									if (col_wraps) begin
										state_q <= ST_LINE;
									end else begin
										cursor_col_q <= col_inc[POS_W-1:0];
										state_q      <= ST_IDLE;
									end
								end
							endcase
						end
					end
				end
				ST_TAB: begin
					if (tab_here) begin
						if (slot_free) begin
							out_act_q    <= ACT_DRAW;
							out_data_q   <= {bg_color_q, fg_color_q, CH_SPACE,
								cursor_row_q, cursor_col_q};
							out_last_q   <= !tab_more && !(col_inc >= cols_ext && line_scrolls);
							cursor_col_q <= col_inc[POS_W-1:0];
						end
					end else if (col_ext >= cols_ext) begin
						state_q <= ST_LINE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LINE: begin
					if (line_scrolls) begin
						if (slot_free) begin
							out_act_q    <= ACT_SCROLL;
							out_data_q   <= '0;
							out_last_q   <= 1'b1;
							cursor_col_q <= '0;
							state_q      <= ST_IDLE;
						end
					end else begin
						cursor_col_q <= '0;
						cursor_row_q <= row_inc[POS_W-1:0];
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a command while the previous one is in flight");

	a_clear_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_CLEAR) |-> m_tlast)
		else $error("clear result not marked last");

	a_nondraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ACT_DRAW) |-> (m_tdata == '0))
		else $error("scroll or clear result carries draw fields");

	a_tab_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAB) |-> ({1'b0, cursor_col_q} <= tab_stop_q))
		else $error("tab ran past its stop");
`endif

endmodule
